// File: rtl/core/lsd_pkg.sv
package lsd_pkg;

	localparam int LINE_LENGTH = 128;

	localparam int PIX_W   = 16;
	localparam int POS_W   = 7;
	localparam int SLOPE_W = 16;
	localparam int CNT_W   = $clog2(LINE_LENGTH);

	// Width used to form a position before it is cut to POS_W bits.
	localparam int PCALC_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int BOX_LEN   = 7;
	localparam int TAPS      = BOX_LEN + 2;
	localparam int LEAD      = 4;
	localparam int EDGE_BAND = 5;
	localparam int TAIL_CNT  = 4;
	localparam int TAIL_W    = 3;

	// Sum of seven samples.
	localparam int SUM_W = PIX_W + 3;

	// floor(x / 7) = (x * RECIP) >> RECIP_SHIFT, exact for every x below 2**SUM_W.
	localparam int RECIP_SHIFT = SUM_W + 3;
	localparam int RECIP       = ((2 ** RECIP_SHIFT) + BOX_LEN - 1) / BOX_LEN;
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             band;
		logic             last;
	} lsd_ctl_t;

endpackage

// File: rtl/core/lsd_front.sv
module lsd_front import lsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             take_s2,
	output logic             valid_s2,
	output lsd_ctl_t         ctl_s2,
	output logic [SUM_W-1:0] sum_a_s2,
	output logic [SUM_W-1:0] sum_b_s2
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LENGTH - 1);
	localparam logic [CNT_W-1:0] CNT_BAND = CNT_W'(LEAD + EDGE_BAND);

	logic [PIX_W-1:0] taps_q [TAPS];
	logic [CNT_W-1:0] cnt_q;
	logic             valid_s1;
	lsd_ctl_t         ctl_s1;

	logic             s2_open;
	logic             s1_open;
	logic             accept;
	logic [PCALC_W-1:0] pos_full;
	logic [SUM_W-1:0] sum_a;
	logic [SUM_W-1:0] sum_b;

	assign s2_open  = !valid_s2 || take_s2;
	assign s1_open  = !valid_s1 || s2_open;
	assign in_stall = !s1_open;
	assign accept   = in_valid && s1_open;
	assign pos_full = PCALC_W'(cnt_q) - PCALC_W'(LEAD);

	// The tap line holds the nine samples around the position in stage one.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				taps_q[k] <= taps_q[k+1];
			end
			taps_q[TAPS-1] <= pixel_value;
			ctl_s1.pos  <= pos_full[POS_W-1:0];
			ctl_s1.band <= (cnt_q >= CNT_BAND) && (cnt_q != CNT_LAST);
			ctl_s1.last <= (cnt_q == CNT_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q    <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
				valid_s1 <= (cnt_q >= CNT_W'(LEAD));
			end else if (s2_open) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int k = 0; k < BOX_LEN; k++) begin
			sum_a = sum_a + SUM_W'(taps_q[k]);
			sum_b = sum_b + SUM_W'(taps_q[k+2]);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_open && valid_s1) begin
			sum_a_s2 <= sum_a;
			sum_b_s2 <= sum_b;
			ctl_s2   <= ctl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

endmodule

// File: rtl/core/line_smooth_derivative.sv
// Streaming smoothed derivative of one sensor line. Each word on the input is the next
// unsigned pixel of a LINE_LENGTH-pixel line; each output word carries the position, the
// difference of the 7-sample box averages left and right of it (saturated to signed
// 16 bits) and an end-of-line flag. Positions in the first and last five of a line read
// zero. Pixels are taken one per cycle while in_stall is low, through a three-register
// pipeline (tap line, sum stage, output register); each word passes from the tap line
// through the sum stage into the output register. The last pixel of a line releases five
// words; the output register issues the four extra zero words itself, one per cycle while
// out_stall is low. They overlap the first four pixels of the next line, which release no
// words, so no pixel waits on them unless a side stalls. No clearing pass follows reset.
module line_smooth_derivative import lsd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIX_W-1:0]          pixel_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [POS_W-1:0]          position,
	output logic signed [SLOPE_W-1:0] slope_value,
	output logic                      end_of_line
);

	localparam logic [POS_W-1:0]   POS_LAST = POS_W'(LINE_LENGTH - 1);
	localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP);

	logic               valid_s2;
	lsd_ctl_t           ctl_s2;
	logic [SUM_W-1:0]   sum_a_s2;
	logic [SUM_W-1:0]   sum_b_s2;

	logic [TAIL_W-1:0]  tail_q;
	logic               out_load;
	logic [PROD_W-1:0]  prod_a;
	logic [PROD_W-1:0]  prod_b;
	logic [PIX_W-1:0]   avg_a;
	logic [PIX_W-1:0]   avg_b;
	logic signed [PIX_W:0] diff;
	logic signed [SLOPE_W-1:0] slope_sat;

	lsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.take_s2     (out_load),
		.valid_s2    (valid_s2),
		.ctl_s2      (ctl_s2),
		.sum_a_s2    (sum_a_s2),
		.sum_b_s2    (sum_b_s2)
	);

	assign out_load = !out_valid || (!out_stall && (tail_q == '0));

	assign prod_a = PROD_W'(sum_a_s2) * PROD_W'(RECIP_K);
	assign prod_b = PROD_W'(sum_b_s2) * PROD_W'(RECIP_K);
	assign avg_a  = prod_a[RECIP_SHIFT +: PIX_W];
	assign avg_b  = prod_b[RECIP_SHIFT +: PIX_W];
	assign diff   = $signed({1'b0, avg_a}) - $signed({1'b0, avg_b});

	// The top two bits of the difference disagree only when it leaves the signed range.
	always_comb begin
		if (!diff[PIX_W] && diff[PIX_W-1]) begin
			slope_sat = {1'b0, {(SLOPE_W-1){1'b1}}};
		end else if (diff[PIX_W] && !diff[PIX_W-1]) begin
			slope_sat = {1'b1, {(SLOPE_W-1){1'b0}}};
		end else begin
			slope_sat = diff[SLOPE_W-1:0];
		end
	end

	// After the last pixel's word is taken, the register steps through the
	// trailing zero words of the line before it loads again.
	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			position    <= ctl_s2.pos;
			slope_value <= ctl_s2.band ? slope_sat : '0;
			end_of_line <= 1'b0;
		end else if (out_valid && !out_stall && (tail_q != '0)) begin
			position    <= position + 1'b1;
			slope_value <= '0;
			end_of_line <= (tail_q == TAIL_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			tail_q    <= '0;
		end else if (out_load) begin
			out_valid <= valid_s2;
			tail_q    <= (valid_s2 && ctl_s2.last) ? TAIL_W'(TAIL_CNT) : '0;
		end else if (out_valid && !out_stall) begin
			tail_q <= tail_q - 1'b1;
		end
	end

	a_tail_held: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q != '0) |-> out_valid)
		else $error("trailing words pending without a valid output word");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && (tail_q != '0)) |=> (out_valid && (slope_value == '0)))
		else $error("trailing word missing or nonzero");

	a_eol_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_line) |-> ((position == POS_LAST) && (slope_value == '0)))
		else $error("end of line on a wrong word");

	a_no_load_in_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q != '0) |-> !out_load)
		else $error("output register reloaded during trailing words");

endmodule
